@@ hw/rtl/sdac_pkg.sv @@
// shared types, constants and frame helpers for the serial dac command serializer
// no dependencies; imported by every module of the block
package sdac_pkg;

    localparam int FRAME_BITS_DEF = 24;
    localparam int OPCODE_W       = 3;
    localparam int CODE_W         = 16;
    localparam int RES_W          = 5;
    localparam int CMD_W          = 4;

    localparam logic [RES_W-1:0] RES_RESET = RES_W'(12);
    localparam logic [RES_W-1:0] RES_12    = RES_W'(12);
    localparam logic [RES_W-1:0] RES_10    = RES_W'(10);
    localparam logic [RES_W-1:0] RES_8     = RES_W'(8);

    localparam logic [CODE_W-1:0] MASK_12 = 16'h0FFF;
    localparam logic [CODE_W-1:0] MASK_10 = 16'h03FF;
    localparam logic [CODE_W-1:0] MASK_8  = 16'h00FF;

    localparam logic [CMD_W-1:0] DAC_CMD_LOAD_INPUT = 4'h0;
    localparam logic [CMD_W-1:0] CMD_UPDATE         = 4'h1;
    localparam logic [CMD_W-1:0] CMD_WRITE_UPDATE   = 4'h3;
    localparam logic [CMD_W-1:0] DAC_CMD_SHUTDOWN   = 4'h4;
    localparam logic [CMD_W-1:0] CMD_INTERNAL_REF   = 4'h6;
    localparam logic [CMD_W-1:0] CMD_SUPPLY_REF     = 4'h7;

    typedef enum logic [OPCODE_W-1:0] {
        OP_TICK         = 3'd0,
        OP_WRITE_INPUT  = 3'd1,
        OP_UPDATE       = 3'd2,
        OP_POWER_DOWN   = 3'd3,
        OP_INTERNAL_REF = 3'd4,
        OP_SUPPLY_REF   = 3'd5,
        OP_WRITE_UPDATE = 3'd6
    } op_t;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [CODE_W-1:0]   dac_code;
    } item_t;

    // mask to resolution and left-align in 16 bits; unsupported widths give zero
    function automatic logic [CODE_W-1:0] code_field(
        input logic [RES_W-1:0]  res,
        input logic [CODE_W-1:0] code
    );
        logic [CODE_W-1:0] f;
        f = '0;
        if (res == RES_12)
            f = (code & MASK_12) << 4;
        else if (res == RES_10)
            f = (code & MASK_10) << 6;
        else if (res == RES_8)
            f = (code & MASK_8) << 8;
        return f;
    endfunction

endpackage

@@ hw/rtl/sdac_in_stage.sv @@
// input register stage: holds one accepted beat until the engine takes it
// depends on sdac_pkg for the item struct
module sdac_in_stage
    import sdac_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  item_t in_item,
    output logic  s1_valid,
    input  logic  s1_take,
    output item_t s1_item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign in_ready   = !valid_reg || s1_take;
    assign valid_next = (in_valid && in_ready) || (valid_reg && !s1_take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign s1_valid = valid_reg;
    assign s1_item  = item_reg;

endmodule

@@ hw/rtl/sdac_engine.sv @@
// frame state, one-phase-per-tick update and the result register
// depends on sdac_pkg for opcodes, dac commands and the code field helper
module sdac_engine
    import sdac_pkg::*;
#(
    parameter int FRAME_BITS = FRAME_BITS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_write_en,
    input  logic [RES_W-1:0] cfg_write_data,
    input  logic             s1_valid,
    output logic             s1_take,
    input  item_t            s1_item,
    output logic             out_valid,
    input  logic             out_ready,
    output logic             chip_select_n,
    output logic             serial_clock,
    output logic             serial_data,
    output logic             busy_res,
    output logic             rejected,
    output logic             frame_done
);

    localparam int PW = $clog2(2 * FRAME_BITS + 3);
    localparam logic [PW-1:0] LAST_BIT_PHASE = PW'(2 * FRAME_BITS);
    localparam logic [PW-1:0] HOLD_PHASE     = PW'(2 * FRAME_BITS + 1);

    logic [RES_W-1:0]      res_reg;
    logic [FRAME_BITS-1:0] shift_reg, shift_next;
    logic [PW-1:0]         phase_reg, phase_next;
    logic                  active_reg, active_next;
    logic                  sel_reg, sel_next;
    logic                  clk_lvl_reg, clk_lvl_next;
    logic                  dat_reg, dat_next;

    logic                  out_valid_reg;
    logic                  cs_out_reg, sck_out_reg, sd_out_reg;
    logic                  busy_out_reg, rej_out_reg, done_out_reg;

    logic                  is_cmd;
    logic                  uses_code;
    logic [CMD_W-1:0]      cmd;
    logic [CODE_W-1:0]     data;
    logic [FRAME_BITS-1:0] data_fit;
    logic [FRAME_BITS-1:0] new_frame;
    logic                  busy_c, rej_c, done_c;

    assign s1_take = s1_valid && (!out_valid_reg || out_ready);

    always_comb
    begin
        is_cmd    = 1'b1;
        uses_code = 1'b0;
        cmd       = DAC_CMD_LOAD_INPUT;
        unique case (op_t'(s1_item.opcode))
            OP_WRITE_INPUT:
            begin
                cmd       = DAC_CMD_LOAD_INPUT;
                uses_code = 1'b1;
            end
            OP_UPDATE:       cmd = CMD_UPDATE;
            OP_POWER_DOWN:   cmd = DAC_CMD_SHUTDOWN;
            OP_INTERNAL_REF: cmd = CMD_INTERNAL_REF;
            OP_SUPPLY_REF:   cmd = CMD_SUPPLY_REF;
            OP_WRITE_UPDATE:
            begin
                cmd       = CMD_WRITE_UPDATE;
                uses_code = 1'b1;
            end
            // tick, and the unused code, advance the frame
            default:         is_cmd = 1'b0;
        endcase
    end

    assign data = uses_code ? code_field(res_reg, s1_item.dac_code) : '0;

    generate
        if (FRAME_BITS > CODE_W)
        begin : g_wide
            assign data_fit = {{(FRAME_BITS - CODE_W){1'b0}}, data};
        end
        else if (FRAME_BITS == CODE_W)
        begin : g_even
            assign data_fit = data;
        end
        else
        begin : g_narrow
            assign data_fit = data[FRAME_BITS-1:0];
        end
    endgenerate

    // command sits in the top four bits, or-ed over the code on short frames
    assign new_frame = {cmd, {(FRAME_BITS - CMD_W){1'b0}}} | data_fit;

    always_comb
    begin
        shift_next   = shift_reg;
        phase_next   = phase_reg;
        active_next  = active_reg;
        sel_next     = sel_reg;
        clk_lvl_next = clk_lvl_reg;
        dat_next     = dat_reg;
        busy_c       = 1'b0;
        rej_c        = 1'b0;
        done_c       = 1'b0;
        if (is_cmd)
        begin
            busy_c = 1'b1;
            if (active_reg)
            begin
                rej_c = 1'b1;
            end
            else
            begin
                shift_next  = new_frame;
                phase_next  = '0;
                active_next = 1'b1;
            end
        end
        else if (active_reg)
        begin
            busy_c     = 1'b1;
            phase_next = phase_reg + 1'b1;
            if (phase_reg == '0)
            begin
                sel_next = 1'b0;
            end
            else if (phase_reg <= LAST_BIT_PHASE)
            begin
                if (phase_reg[0])
                begin
                    // first half of a bit: present msb, clock low
                    dat_next     = shift_reg[FRAME_BITS-1];
                    shift_next   = shift_reg << 1;
                    clk_lvl_next = 1'b0;
                end
                else
                begin
                    clk_lvl_next = 1'b1;
                end
            end
            else if (phase_reg == HOLD_PHASE)
            begin
                clk_lvl_next = 1'b0;
            end
            else
            begin
                sel_next    = 1'b1;
                active_next = 1'b0;
                phase_next  = '0;
                done_c      = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_reg     <= RES_RESET;
            shift_reg   <= '0;
            phase_reg   <= '0;
            active_reg  <= 1'b0;
            sel_reg     <= 1'b1;
            clk_lvl_reg <= 1'b0;
            dat_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                res_reg <= cfg_write_data;
            end
            if (s1_take)
            begin
                shift_reg   <= shift_next;
                phase_reg   <= phase_next;
                active_reg  <= active_next;
                sel_reg     <= sel_next;
                clk_lvl_reg <= clk_lvl_next;
                dat_reg     <= dat_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_take)
        begin
            cs_out_reg   <= sel_next;
            sck_out_reg  <= clk_lvl_next;
            sd_out_reg   <= dat_next;
            busy_out_reg <= busy_c;
            rej_out_reg  <= rej_c;
            done_out_reg <= done_c;
        end
    end

    assign out_valid     = out_valid_reg;
    assign chip_select_n = cs_out_reg;
    assign serial_clock  = sck_out_reg;
    assign serial_data   = sd_out_reg;
    assign busy_res      = busy_out_reg;
    assign rejected      = rej_out_reg;
    assign frame_done    = done_out_reg;

endmodule

@@ hw/rtl/spi_dac_command_serializer.sv @@
// Serial dac command serializer. Each beat on the input is either a command (builds a frame
// of FRAME_BITS bits: 4-bit dac command on top, resolution-masked left-aligned code below)
// or a tick that plays out one pin phase: select low, two ticks per bit msb first (data with
// clock low, then clock high), a hold tick, then select high with frame_done. Every input
// beat yields exactly one output beat with the pin levels after it and status flags. One
// beat is taken per clock; each beat passes through the input register and then the result
// register, and the input stalls only while the result register is held by out_ready.
// A full frame takes 2*FRAME_BITS+3 ticks after its command; a command during a frame is rejected.
module spi_dac_command_serializer
    import sdac_pkg::*;
#(
    parameter int FRAME_BITS = FRAME_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write_en,
    input  logic [RES_W-1:0]    cfg_write_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [OPCODE_W-1:0] opcode,
    input  logic [CODE_W-1:0]   dac_code,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                chip_select_n,
    output logic                serial_clock,
    output logic                serial_data,
    output logic                busy_res,
    output logic                rejected,
    output logic                frame_done
);

    item_t in_item;
    item_t s1_item;
    logic  s1_valid;
    logic  s1_take;

    assign in_item.opcode   = opcode;
    assign in_item.dac_code = dac_code;

    sdac_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_item  (in_item),
        .s1_valid (s1_valid),
        .s1_take  (s1_take),
        .s1_item  (s1_item)
    );

    sdac_engine #(
        .FRAME_BITS (FRAME_BITS)
    ) u_engine (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .s1_valid       (s1_valid),
        .s1_take        (s1_take),
        .s1_item        (s1_item),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .chip_select_n  (chip_select_n),
        .serial_clock   (serial_clock),
        .serial_data    (serial_data),
        .busy_res       (busy_res),
        .rejected       (rejected),
        .frame_done     (frame_done)
    );

endmodule

@@ hw/rtl/sdac_checker.sv @@
// port-level checks for the serial dac command serializer, bound to the top level
// depends on sdac_pkg for field widths
module sdac_checker
    import sdac_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic [OPCODE_W-1:0] opcode,
    input logic [CODE_W-1:0]   dac_code,
    input logic                out_valid,
    input logic                out_ready,
    input logic                chip_select_n,
    input logic                serial_clock,
    input logic                serial_data,
    input logic                busy_res,
    input logic                rejected,
    input logic                frame_done
);

    // an idle result always shows the bus parked
    a_idle_parked: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !busy_res) |-> (chip_select_n && !serial_clock))
        else $error("idle result with bus not parked");

    // the serial clock only runs while the dac is selected
    a_clock_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && serial_clock) |-> !chip_select_n)
        else $error("serial clock high while deselected");

    // a finishing beat is a tick, never a dropped command, and ends deselected
    a_done_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && frame_done) |-> (!rejected && busy_res && chip_select_n))
        else $error("bad frame_done beat");

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(chip_select_n)
            && $stable(serial_clock) && $stable(serial_data) && $stable(busy_res)
            && $stable(rejected) && $stable(frame_done)))
        else $error("output beat changed while stalled");

    // a waiting input beat holds
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_ready) |=> (in_valid && $stable(opcode) && $stable(dac_code)))
        else $error("input beat changed while waiting");

endmodule

bind spi_dac_command_serializer sdac_checker u_sdac_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .opcode        (opcode),
    .dac_code      (dac_code),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .chip_select_n (chip_select_n),
    .serial_clock  (serial_clock),
    .serial_data   (serial_data),
    .busy_res      (busy_res),
    .rejected      (rejected),
    .frame_done    (frame_done)
);
